@@ sv/mods_pkg.sv @@
// Shared types and constants for the mask outline dilation stream.
// Used by mods_pos, mods_core and mask_outline_dilate_stream.
package mods_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MAX     = 2'd3;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [PIX_W-1:0]      ALPHA_MIN_RST    = 8'd20;
  localparam logic [PIX_W-1:0]      GRAY_MAX_RST     = 8'd200;

  // per-request position flags, worked out when the request is taken
  typedef struct packed {
    logic pix;   // position lies inside the frame's pixels
    logic ev;    // the pixel one row back exists in the frame
    logic eb;    // that pixel lies on the image border
    logic emit;  // this request produces a result
    logic last;  // result of the frame's last pixel
  } item_flags_t;

endpackage

@@ sv/mods_ram.sv @@
// Simple dual-port RAM with registered read and write-through on a collision.
// No dependencies.
module mods_ram #(
  parameter int DEPTH = 2048,
  parameter int DW    = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mods_pos.sv @@
// Request position tracking: column, row and count within the frame.
// Depends on mods_pkg for item_flags_t.
module mods_pos #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              restart,
  input  logic                              accept,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
  output logic [$clog2(MAX_WIDTH)-1:0]      x_cur,
  output logic [$clog2(MAX_WIDTH)-1:0]      x_prev,
  output mods_pkg::item_flags_t             flags
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XA = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT + 4);
  localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);

  logic [TW-1:0] t_r, t_nxt;
  logic [XA-1:0] x_r, x_nxt, xp_r;
  logic [YW-1:0] y_r, y_nxt;

  logic [TW-1:0] n_pix, lead, last_t;
  logic [WW-1:0] w_m1;
  logic [YW-1:0] h_y;
  logic          x_end;

  always_comb begin
    n_pix  = TW'(w_eff) * TW'(h_eff);
    lead   = (TW'(w_eff) << 1) + TW'(2);
    last_t = n_pix + lead - TW'(1);
    w_m1   = w_eff - WW'(1);
    h_y    = YW'(h_eff);
    x_end  = WW'(x_r) == w_m1;

    flags.pix  = y_r < h_y;
    flags.ev   = (y_r != '0) && (y_r <= h_y);
    flags.eb   = (x_r == '0) || x_end || (y_r == YW'(1)) || (y_r == h_y);
    flags.emit = t_r >= lead;
    flags.last = t_r == last_t;

    t_nxt = t_r;
    x_nxt = x_r;
    y_nxt = y_r;
    if (restart) begin
      t_nxt = '0;
      x_nxt = '0;
      y_nxt = '0;
    end else if (accept) begin
      if (flags.last) begin
        t_nxt = '0;
        x_nxt = '0;
        y_nxt = '0;
      end else begin
        t_nxt = t_r + TW'(1);
        if (x_end) begin
          x_nxt = '0;
          y_nxt = y_r + YW'(1);
        end else begin
          x_nxt = x_r + XA'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r  <= '0;
      x_r  <= '0;
      y_r  <= '0;
      xp_r <= '0;
    end else begin
      t_r <= t_nxt;
      x_r <= x_nxt;
      y_r <= y_nxt;
      if (accept) begin
        xp_r <= x_r;
      end
    end
  end

  assign x_cur  = x_r;
  assign x_prev = xp_r;

endmodule

@@ sv/mods_core.sv @@
// Pixel register, mask/edge row buffers, 3x3 dilation and result register.
// Depends on mods_pkg and mods_ram.
module mods_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 restart,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mods_pkg::PIX_W-1:0]           alpha,
  input  logic [mods_pkg::PIX_W-1:0]           red,
  input  logic [mods_pkg::PIX_W-1:0]           green,
  input  logic [mods_pkg::PIX_W-1:0]           blue,
  input  logic                                 drain,
  input  mods_pkg::item_flags_t                flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]         x_cur,
  input  logic [$clog2(MAX_WIDTH)-1:0]         x_prev,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      h_eff,
  input  logic [mods_pkg::PIX_W-1:0]           alpha_min,
  input  logic [mods_pkg::PIX_W-1:0]           gray_max,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 mark,
  output logic                                 end_of_frame
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XA = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT + 4);
  localparam int SW = 2 * mods_pkg::PIX_W - 3;
  localparam logic [SW-1:0] COEF_R = SW'(11);
  localparam logic [SW-1:0] COEF_G = SW'(16);
  localparam logic [SW-1:0] COEF_B = SW'(5);

  logic                         s1_valid_r;
  logic [mods_pkg::PIX_W-1:0]   s1_alpha_r, s1_red_r, s1_green_r, s1_blue_r;
  logic                         s1_drain_r;
  mods_pkg::item_flags_t        s1_flags_r;
  logic [XA-1:0]                s1_x_r, s1_xe_r;

  logic                         mb_p1_r, mb_p2_r, ma_p1_r, mc_p1_r, ev_p1_r, eb_p1_r;
  logic [2:0]                   win_r [2];
  logic [XA-1:0]                kx_r, kx_nxt;
  logic [YW-1:0]                ky_r, ky_nxt;
  logic                         out_valid_r, out_mark_r, out_eof_r;

  logic                         accept, exec;
  logic [1:0]                   m_rd, e_rd, m_wd, e_wd;
  logic [SW-1:0]                gray_sum;
  logic [mods_pkg::PIX_W-1:0]   gray;
  logic                         m_cur, m_b, m_a, edge_new;
  logic [2:0]                   col_new, row_keep;
  logic                         keep_l, keep_r, mark_c;
  logic                         kx_end;

  assign exec     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || exec;
  assign accept   = in_valid && in_ready;

  // mask rows: [1] two rows back, [0] one row back
  mods_ram #(.DEPTH(MAX_WIDTH), .DW(2)) u_mask_rows (
    .clk   (clk),
    .we    (exec),
    .waddr (s1_x_r),
    .wdata (m_wd),
    .re    (accept),
    .raddr (x_cur),
    .rdata (m_rd)
  );

  // edge rows: [1] one row back, [0] two rows back
  mods_ram #(.DEPTH(MAX_WIDTH), .DW(2)) u_edge_rows (
    .clk   (clk),
    .we    (exec),
    .waddr (s1_xe_r),
    .wdata (e_wd),
    .re    (accept),
    .raddr (x_prev),
    .rdata (e_rd)
  );

  always_comb begin
    gray_sum = SW'(s1_red_r) * COEF_R + SW'(s1_green_r) * COEF_G
             + SW'(s1_blue_r) * COEF_B;
    gray     = gray_sum[SW-1:5];
    m_cur    = s1_flags_r.pix && !s1_drain_r && (s1_alpha_r >= alpha_min)
             && (gray < gray_max);
    m_a      = m_rd[1];
    m_b      = m_rd[0];
    m_wd     = {m_b, m_cur};

    // edge of the pixel one row and one column back
    edge_new = ev_p1_r && mb_p1_r
             && (eb_p1_r || !mb_p2_r || !m_b || !ma_p1_r || !mc_p1_r);
    col_new  = {edge_new, e_rd[1], e_rd[0]};
    e_wd     = {edge_new, e_rd[1]};

    kx_end   = WW'(kx_r) == (w_eff - WW'(1));
    row_keep = {ky_r != YW'(h_eff) - YW'(1), 1'b1, ky_r != '0};
    keep_r   = !kx_end;
    keep_l   = kx_r != '0;
    mark_c   = (|(col_new & row_keep) && keep_r)
             || (|(win_r[0] & row_keep))
             || (|(win_r[1] & row_keep) && keep_l);

    kx_nxt = kx_r;
    ky_nxt = ky_r;
    if (restart) begin
      kx_nxt = '0;
      ky_nxt = '0;
    end else if (exec && s1_flags_r.emit) begin
      if (s1_flags_r.last) begin
        kx_nxt = '0;
        ky_nxt = '0;
      end else if (kx_end) begin
        kx_nxt = '0;
        ky_nxt = ky_r + YW'(1);
      end else begin
        kx_nxt = kx_r + XA'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ev_p1_r     <= 1'b0;
      kx_r        <= '0;
      ky_r        <= '0;
      win_r[0]    <= '0;
      win_r[1]    <= '0;
    end else begin
      kx_r <= kx_nxt;
      ky_r <= ky_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (exec) begin
        s1_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= s1_flags_r.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (restart) begin
        ev_p1_r <= 1'b0;
      end else if (exec) begin
        ev_p1_r <= s1_flags_r.ev;
      end
      if (exec) begin
        win_r[0] <= col_new;
        win_r[1] <= win_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_alpha_r <= alpha;
      s1_red_r   <= red;
      s1_green_r <= green;
      s1_blue_r  <= blue;
      s1_drain_r <= drain;
      s1_flags_r <= flags;
      s1_x_r     <= x_cur;
      s1_xe_r    <= x_prev;
    end
    if (exec) begin
      mb_p1_r    <= m_b;
      mb_p2_r    <= mb_p1_r;
      ma_p1_r    <= m_a;
      mc_p1_r    <= m_cur;
      eb_p1_r    <= s1_flags_r.eb;
      out_mark_r <= mark_c;
      out_eof_r  <= s1_flags_r.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign mark         = out_mark_r;
  assign end_of_frame = out_eof_r;

endmodule

@@ sv/mask_outline_dilate_stream.sv @@
// Top level: configuration registers, position tracking and the pixel core.
// Depends on mods_pkg, mods_pos, mods_core (and mods_ram below it).
//
// Usage: ARGB pixels enter in raster order on the in_ channel (valid/ready).
// A pixel is in the mask when opaque (alpha >= alpha_min) and dark
// (gray < gray_max); mask pixels on the border or beside a clear pixel are
// edges, and out_mark is the OR of edges over the 3x3 neighborhood.
// After the frame's W*H pixels send 2W+2 requests with in_drain set; the
// result for pixel k leaves with request k+2W+2, so the first 2W+2 requests
// of a frame give no result. out_end_of_frame flags the last pixel's result.
// A request's result is registered first in the pixel register, then in the result register.
// Throughput: one request per cycle while out_ready is high, set by the single pass
// from the pixel register through the row buffers to the result register.
// Row buffers are column-indexed RAMs of MAX_WIDTH entries.
// Configuration (cfg_wr_en/cfg_index/cfg_data) is written while idle; a
// width or height write restarts the frame. Reset is synchronous, active
// low, and restores 640x480, alpha_min 20, gray_max 200.
// A stalled out_ready holds the result; one more request is buffered before
// in_ready drops.
module mask_outline_dilate_stream #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mods_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mods_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mods_pkg::PIX_W-1:0]          in_alpha,
  input  logic [mods_pkg::PIX_W-1:0]          in_red,
  input  logic [mods_pkg::PIX_W-1:0]          in_green,
  input  logic [mods_pkg::PIX_W-1:0]          in_blue,
  input  logic                                in_drain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_mark,
  output logic                                out_end_of_frame
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XA = $clog2(MAX_WIDTH);

  logic [mods_pkg::CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  logic [mods_pkg::PIX_W-1:0]      alpha_min_r, gray_max_r;

  logic [31:0]           fw32, fh32;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic                  restart, accept;
  logic [XA-1:0]         x_cur, x_prev;
  mods_pkg::item_flags_t flags;

  assign restart = cfg_wr_en && (cfg_index == mods_pkg::REG_FRAME_WIDTH
                              || cfg_index == mods_pkg::REG_FRAME_HEIGHT);
  assign accept  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mods_pkg::FRAME_WIDTH_RST;
      frame_height_r <= mods_pkg::FRAME_HEIGHT_RST;
      alpha_min_r    <= mods_pkg::ALPHA_MIN_RST;
      gray_max_r     <= mods_pkg::GRAY_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mods_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        mods_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        mods_pkg::REG_ALPHA_MIN:    alpha_min_r    <= cfg_data[mods_pkg::PIX_W-1:0];
        mods_pkg::REG_GRAY_MAX:     gray_max_r     <= cfg_data[mods_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame size to 1..MAX
  always_comb begin
    fw32  = 32'(frame_width_r);
    fh32  = 32'(frame_height_r);
    w_eff = (fw32 == '0) ? WW'(1) :
            (fw32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw32);
    h_eff = (fh32 == '0) ? HW'(1) :
            (fh32 > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(fh32);
  end

  mods_pos #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .accept  (accept),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .x_cur   (x_cur),
    .x_prev  (x_prev),
    .flags   (flags)
  );

  mods_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .alpha        (in_alpha),
    .red          (in_red),
    .green        (in_green),
    .blue         (in_blue),
    .drain        (in_drain),
    .flags        (flags),
    .x_cur        (x_cur),
    .x_prev       (x_prev),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .alpha_min    (alpha_min_r),
    .gray_max     (gray_max_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mark         (out_mark),
    .end_of_frame (out_end_of_frame)
  );

endmodule

@@ bench/mods_outline_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for mask_outline_dilate_stream: watches config writes, the request and result channels,
// predicts mark/end_of_frame per accepted request and compares in order.
// Depends on mods_pkg only.
module mods_outline_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mods_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mods_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [mods_pkg::PIX_W-1:0]      in_alpha,
  input  logic [mods_pkg::PIX_W-1:0]      in_red,
  input  logic [mods_pkg::PIX_W-1:0]      in_green,
  input  logic [mods_pkg::PIX_W-1:0]      in_blue,
  input  logic                            in_drain,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_mark,
  input  logic                            out_end_of_frame,
  output int                              errors,
  output int                              pending,
  output int                              checked,
  output int                              frames_done
);

  localparam int HIST = 4 * MAX_WIDTH;

  typedef struct packed {
    logic mark;
    logic eof;
  } outline_t;

  outline_t                          marks_due[$];
  outline_t                          want;
  outline_t                          got;
  bit                                mask_hist [HIST];
  bit                                rim_hist [HIST];
  logic [mods_pkg::CFG_DATA_W-1:0]   width_reg;
  logic [mods_pkg::CFG_DATA_W-1:0]   height_reg;
  logic [mods_pkg::PIX_W-1:0]        alpha_floor;
  logic [mods_pkg::PIX_W-1:0]        gray_ceil;
  int                                pix_pos;

  function automatic bit mask_px(input int p);
    return mask_hist[p % HIST];
  endfunction

  // one request through the window pipeline; returns 1 when a result leaves
  function automatic bit outline_step(input logic [mods_pkg::PIX_W-1:0] a, r, g, b,
                                      input logic drn, output outline_t res);
    int w, h, n, t, e, k, x, y, gray, dx, dy, nx, ny;
    bit hit;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
    n = w * h;
    t = pix_pos;
    res = '0;
    if (t < n) begin
      gray = (11 * int'(r) + 16 * int'(g) + 5 * int'(b)) >> 5;
      mask_hist[t % HIST] = !drn && (a >= alpha_floor) && (gray < int'(gray_ceil));
    end
    e = t - w;
    if (e >= 0 && e < n) begin
      x = e % w;
      y = e / w;
      hit = 1'b0;
      if (mask_px(e)) begin
        if (x == 0 || y == 0 || x == w - 1 || y == h - 1) begin
          hit = 1'b1;
        end else begin
          hit = !mask_px(e - 1) || !mask_px(e + 1) || !mask_px(e - w) || !mask_px(e + w);
        end
      end
      rim_hist[e % HIST] = hit;
    end
    pix_pos = t + 1;
    k = t - 2 * w - 2;
    if (k < 0 || k >= n) return 1'b0;
    x = k % w;
    y = k / w;
    hit = 1'b0;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        nx = x + dx;
        ny = y + dy;
        if (nx >= 0 && ny >= 0 && nx < w && ny < h) hit |= rim_hist[(ny * w + nx) % HIST];
      end
    end
    res.mark = hit;
    res.eof  = (k == n - 1);
    if (k == n - 1) pix_pos = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg   = mods_pkg::FRAME_WIDTH_RST;
      height_reg  = mods_pkg::FRAME_HEIGHT_RST;
      alpha_floor = mods_pkg::ALPHA_MIN_RST;
      gray_ceil   = mods_pkg::GRAY_MAX_RST;
      pix_pos     = 0;
      marks_due.delete();
      errors      = 0;
      checked     = 0;
      frames_done = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (marks_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result mark=%0b eof=%0b", $time, out_mark,
                     out_end_of_frame);
        end else begin
          want = marks_due.pop_front();
          checked++;
          if (want.eof) frames_done++;
          if (out_mark !== want.mark || out_end_of_frame !== want.eof) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result %0d mark exp %0b got %0b, eof exp %0b got %0b", $time,
                       checked, want.mark, out_mark, want.eof, out_end_of_frame);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          mods_pkg::REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            pix_pos   = 0;
          end
          mods_pkg::REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            pix_pos    = 0;
          end
          mods_pkg::REG_ALPHA_MIN: alpha_floor = cfg_data[mods_pkg::PIX_W-1:0];
          mods_pkg::REG_GRAY_MAX:  gray_ceil = cfg_data[mods_pkg::PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (outline_step(in_alpha, in_red, in_green, in_blue, in_drain, got))
          marks_due.push_back(got);
      end
    end
    pending = marks_due.size();
  end

endmodule

@@ bench/mask_outline_dilate_stream_test.sv @@
`timescale 1ns / 1ps
// Top of the mask_outline_dilate_stream bench: clock, reset, config writes and pixel requests.
// Depends on mods_pkg, the block under test and mods_outline_checker.
module mask_outline_dilate_stream_test;

  localparam int MAX_DIM      = 2048;
  localparam int RANDOM_ITEMS = 800;
  localparam int LIMIT        = 1000000;

  // {drain, alpha, red, green, blue}
  localparam logic [32:0] DIRECTED_PIX [12] = '{
    33'h0_00_00_00_00, 33'h0_FF_FF_FF_FF, 33'h0_FF_00_00_00, 33'h0_14_00_00_00,
    33'h0_13_00_00_00, 33'h0_FF_C7_C7_C7, 33'h0_FF_C8_C8_C8, 33'h1_FF_00_00_00,
    33'h0_FF_FF_00_00, 33'h0_FF_00_FF_00, 33'h0_FF_00_00_FF, 33'h0_80_00_00_00
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [mods_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mods_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [mods_pkg::PIX_W-1:0]      in_alpha = '0;
  logic [mods_pkg::PIX_W-1:0]      in_red = '0;
  logic [mods_pkg::PIX_W-1:0]      in_green = '0;
  logic [mods_pkg::PIX_W-1:0]      in_blue = '0;
  logic                            in_drain = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_mark;
  logic                            out_end_of_frame;

  int  mark_errors;
  int  marks_pending;
  int  marks_checked;
  int  frames_closed;
  int  requests_sent = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  idle_on = 1'b1;
  int  cur_w = 640;
  int  cur_h = 480;
  int  cur_amin = 20;
  int  cur_gmax = 200;

  mask_outline_dilate_stream u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alpha         (in_alpha),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_drain         (in_drain),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mark         (out_mark),
    .out_end_of_frame (out_end_of_frame)
  );

  mods_outline_checker #(
    .MAX_WIDTH  (MAX_DIM),
    .MAX_HEIGHT (MAX_DIM)
  ) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alpha         (in_alpha),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_drain         (in_drain),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mark         (out_mark),
    .out_end_of_frame (out_end_of_frame),
    .errors           (mark_errors),
    .pending          (marks_pending),
    .checked          (marks_checked),
    .frames_done      (frames_closed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("mask_outline_dilate_stream_test: errors");
      $finish;
    end
  end

  // result backpressure in bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(9, 0) == 0) begin
      hold_left <= int'($urandom_range(11, 0));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [7:0] a, r, g, b, input logic drn);
    int gap;
    gap = (idle_on && $urandom_range(5, 0) == 0) ? int'($urandom_range(12, 1)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_alpha <= a;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_drain <= drn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (marks_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mods_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[mods_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      mods_pkg::REG_FRAME_WIDTH:  cur_w = val;
      mods_pkg::REG_FRAME_HEIGHT: cur_h = val;
      mods_pkg::REG_ALPHA_MIN:    cur_amin = val;
      mods_pkg::REG_GRAY_MAX:     cur_gmax = val;
      default: ;
    endcase
  endtask

  // one frame plus its drain requests; broken frames stop early
  task automatic send_frame(input bit broken);
    int w, h, n, total, density, i;
    logic [7:0] a, r, g, b;
    logic drn;
    w = (cur_w == 0) ? 1 : ((cur_w > MAX_DIM) ? MAX_DIM : cur_w);
    h = (cur_h == 0) ? 1 : ((cur_h > MAX_DIM) ? MAX_DIM : cur_h);
    n = w * h;
    total = n + 2 * w + 2;
    if (broken) total = int'($urandom_range(total - 1, 1));
    case ($urandom_range(3, 0))
      0:       density = 10;
      1:       density = 50;
      2:       density = 85;
      default: density = 97;
    endcase
    for (i = 0; i < total; i++) begin
      if (i < n) begin
        drn = ($urandom_range(15, 0) == 0);
        if ($urandom_range(9, 0) < 3) begin
          a = 8'($urandom);
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end else if ($urandom_range(99, 0) < density && cur_gmax != 0) begin
          a = 8'($urandom_range(255, cur_amin));
          r = 8'($urandom_range(cur_gmax - 1, 0));
          g = 8'($urandom_range(cur_gmax - 1, 0));
          b = 8'($urandom_range(cur_gmax - 1, 0));
        end else if (cur_amin != 0 && $urandom_range(1, 0) == 0) begin
          a = 8'($urandom_range(cur_amin - 1, 0));
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end else begin
          a = 8'($urandom);
          r = 8'($urandom_range(255, cur_gmax));
          g = 8'($urandom_range(255, cur_gmax));
          b = 8'($urandom_range(255, cur_gmax));
        end
      end else begin
        drn = ($urandom_range(15, 0) != 0);
        a = 8'($urandom);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
      send_request(a, r, g, b, drn);
    end
  endtask

  function automatic int pick_dim(input int top);
    case ($urandom_range(11, 0))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 3;
      4:       return int'($urandom_range(top, 13));
      default: return int'($urandom_range(12, 1));
    endcase
  endfunction

  function automatic int pick_level();
    case ($urandom_range(7, 0))
      0:       return 0;
      1:       return 255;
      default: return int'($urandom_range(255, 0));
    endcase
  endfunction

  initial begin
    int i, f, frames, start;
    bit force_size, broke;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed 4x3 frame at reset thresholds
    write_reg(mods_pkg::REG_FRAME_WIDTH, 4);
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 3);
    for (i = 0; i < 12; i++)
      send_request(DIRECTED_PIX[i][31:24], DIRECTED_PIX[i][23:16], DIRECTED_PIX[i][15:8],
                   DIRECTED_PIX[i][7:0], DIRECTED_PIX[i][32]);
    for (i = 0; i < 10; i++)
      send_request((i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'hFF : 8'h00,
                   (i % 2) ? 8'h00 : 8'hFF, (i % 2) ? 8'hFF : 8'h00, i != 3);
    settle();

    // size writes in the middle of a frame restart it
    write_reg(mods_pkg::REG_FRAME_WIDTH, 6);
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 5);
    for (i = 0; i < 8; i++) send_request(8'hFF, 8'h10, 8'h10, 8'h10, 1'b0);
    settle();
    write_reg(mods_pkg::REG_FRAME_WIDTH, 5);
    for (i = 0; i < 20; i++) send_request(8'($urandom), 8'h00, 8'($urandom), 8'h00, 1'b0);
    settle();
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 4);
    send_frame(1'b0);
    settle();

    // threshold extremes
    write_reg(mods_pkg::REG_ALPHA_MIN, 0);
    write_reg(mods_pkg::REG_GRAY_MAX, 255);
    send_frame(1'b0);
    settle();
    write_reg(mods_pkg::REG_ALPHA_MIN, 255);
    write_reg(mods_pkg::REG_GRAY_MAX, 0);
    send_frame(1'b0);
    settle();

    // size extremes, out-of-range values clamp; oversize frames are cut short
    write_reg(mods_pkg::REG_ALPHA_MIN, 20);
    write_reg(mods_pkg::REG_GRAY_MAX, 200);
    write_reg(mods_pkg::REG_FRAME_WIDTH, 0);
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 0);
    send_frame(1'b0);
    settle();
    write_reg(mods_pkg::REG_FRAME_WIDTH, 4095);
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 1);
    for (i = 0; i < 120; i++)
      send_request(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    settle();
    write_reg(mods_pkg::REG_FRAME_WIDTH, 1);
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 4095);
    for (i = 0; i < 200; i++)
      send_request(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    settle();

    // random phases
    start = requests_sent;
    force_size = 1'b1;
    while (requests_sent - start < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(3, 0) != 0);
      if (force_size || $urandom_range(1, 0) == 0)
        write_reg(mods_pkg::REG_FRAME_WIDTH, pick_dim(48));
      if ($urandom_range(1, 0) == 0) write_reg(mods_pkg::REG_FRAME_HEIGHT, pick_dim(16));
      if ($urandom_range(1, 0) == 0) write_reg(mods_pkg::REG_ALPHA_MIN, pick_level());
      if ($urandom_range(1, 0) == 0) write_reg(mods_pkg::REG_GRAY_MAX, pick_level());
      force_size = 1'b0;
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames && !force_size; f++) begin
        broke = ($urandom_range(9, 0) == 0);
        send_frame(broke);
        force_size = broke;
      end
      settle();
    end

    // closing stretch with no idling on either side
    idle_on = 1'b0;
    write_reg(mods_pkg::REG_FRAME_WIDTH, 13);
    write_reg(mods_pkg::REG_FRAME_HEIGHT, 7);
    write_reg(mods_pkg::REG_ALPHA_MIN, 40);
    write_reg(mods_pkg::REG_GRAY_MAX, 150);
    send_frame(1'b0);
    send_frame(1'b0);
    in_valid <= 1'b0;
    while (marks_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d requests, %0d frames closed, %0d marks compared.", requests_sent,
             frames_closed, marks_checked);
    $display("Full frames from 1x1 to 48x16 plus cut-short clamped ones; thresholds hit 0/255.");
    if (mark_errors == 0) begin
      $display("mask_outline_dilate_stream_test: clean");
    end else begin
      $display("mask_outline_dilate_stream_test: errors");
    end
    $finish;
  end

endmodule

@@ mask_outline_dilate_stream.f @@
sv/mods_pkg.sv
sv/mods_ram.sv
sv/mods_pos.sv
sv/mods_core.sv
sv/mask_outline_dilate_stream.sv
bench/mods_outline_checker.sv
bench/mask_outline_dilate_stream_test.sv
